// ===== src/pdf_pkg.sv =====
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types and constants of the pareto dominance filter: the token that
// travels along the compare chain and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pdf_pkg;

    localparam int KEY_W  = 64;
    localparam int DIMS_W = 5;
    localparam int POS_W  = 6;
    localparam int SLOT_W = 11;
    localparam int IDX_W  = 6;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 5'd8;
    localparam logic [IDX_W-1:0]  IDX_SAT    = 6'd63;

    typedef struct packed {
        logic              vld;
        logic              clr;
        logic              last;
        logic              mark;
        logic [POS_W-1:0]  pos;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } tok_t;

endpackage

`default_nettype wire

// ===== src/pareto_dominance_filter.sv =====
// ----------------------------------------------------------------------------
// pareto_dominance_filter
// Skyline filter: streams objects one feature word at a time through a chain
// of store cells and reports each object marked when it is premarked or
// dominated by an earlier unmarked stored object.
//
//   channel | handshake            | payload
//   cfg     | cfg_valid/cfg_ready  | dims_in_use
//   in      | in_valid/in_ready    | req_type, feature_value, premarked
//   out     | out_valid/out_ready  | object_index, marked, overflow
//
// one feature word or clear request per cycle enters the chain while the
// output register is not stalled; after the last feature word a result passes
// the register of every cell and then the output register
// a stalled output register holds the whole chain and drops in_ready
// reset clears control state only, no clearing pass over the store
// ----------------------------------------------------------------------------
`default_nettype none

module pareto_dominance_filter #(
    parameter int MAX_OBJECTS = 64,
    parameter int DIM_LIMIT   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [pdf_pkg::DIMS_W-1:0]    dims_in_use,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic                          req_type,
    input  wire logic signed [pdf_pkg::KEY_W-1:0] feature_value,
    input  wire logic                          premarked,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [pdf_pkg::IDX_W-1:0]     object_index,
    output      logic                          marked,
    output      logic                          overflow
);
    import pdf_pkg::*;

    localparam int FEATS_MAX = 2 * DIM_LIMIT + 3;
    localparam int CW        = $clog2(MAX_OBJECTS + 1);

    logic [DIMS_W-1:0] dims_reg;
    logic [POS_W-1:0]  fpos_reg;
    logic [CW-1:0]     count_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              marked_reg;
    logic              overflow_reg;

    logic              adv;
    logic [DIMS_W-1:0] d_sat;
    logic [POS_W-1:0]  nfeat_m1;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic              room;
    logic              accept;
    tok_t              tok_head;
    tok_t              tok_chain [MAX_OBJECTS+1];
    tok_t              tok_end;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && adv;

    assign d_sat    = (int'(dims_reg) > DIM_LIMIT) ? DIMS_W'(DIM_LIMIT) : dims_reg;
    assign nfeat_m1 = POS_W'({1'b0, d_sat, 1'b0} + 7'd2);
    assign pos      = (fpos_reg > nfeat_m1) ? nfeat_m1 : fpos_reg;
    assign last     = (pos >= nfeat_m1);
    assign room     = (int'(count_reg) < MAX_OBJECTS);

    always_comb
    begin
        tok_head.vld  = in_valid;
        tok_head.clr  = req_type;
        tok_head.last = last;
        tok_head.mark = premarked;
        tok_head.pos  = pos;
        tok_head.slot = SLOT_W'(count_reg);
        tok_head.key  = feature_value;
    end

    assign tok_chain[0] = tok_head;

    for (genvar g = 0; g < MAX_OBJECTS; g++)
    begin : g_cell
        pdf_cell #(
            .IDX       (g),
            .FEATS_MAX (FEATS_MAX)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1])
        );
    end

    assign tok_end = tok_chain[MAX_OBJECTS];

    // configuration and object tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg  <= DIMS_RESET;
            fpos_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                dims_reg <= dims_in_use;
            end
            if (accept)
            begin
                if (req_type)
                begin
                    fpos_reg  <= '0;
                    count_reg <= '0;
                end
                else if (last)
                begin
                    fpos_reg <= '0;
                    if (room)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                else
                begin
                    fpos_reg <= pos + POS_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tok_end.vld && !tok_end.clr && tok_end.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            index_reg    <= (tok_end.slot > SLOT_W'(IDX_SAT)) ? IDX_SAT
                                                               : tok_end.slot[IDX_W-1:0];
            marked_reg   <= tok_end.mark;
            overflow_reg <= (int'(tok_end.slot) >= MAX_OBJECTS);
        end
    end

    assign out_valid    = out_valid_reg;
    assign object_index = index_reg;
    assign marked       = marked_reg;
    assign overflow     = overflow_reg;

endmodule

`default_nettype wire

// ===== src/pdf_cell.sv =====
// ----------------------------------------------------------------------------
// pdf_cell
// One slot of the object store: holds the features of one object, compares
// every passing feature word against its own and hands the word on.
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_cell #(
    parameter int IDX       = 0,
    parameter int FEATS_MAX = 35
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         adv,
    input  wire pdf_pkg::tok_t tok_in,
    output pdf_pkg::tok_t     tok_out
);
    import pdf_pkg::*;

    localparam int AW = (FEATS_MAX > 1) ? $clog2(FEATS_MAX) : 1;

    logic [KEY_W-1:0] mem [FEATS_MAX];
    logic [KEY_W-1:0] rd_reg;
    tok_t             tok_reg;
    logic             valid_reg;
    logic             ge_reg;
    logic             smark_reg;
    logic             ge_eff;
    logic             cand;
    logic             is_new;

    assign is_new = (tok_reg.slot == SLOT_W'(IDX));
    assign ge_eff = ge_reg && !($signed(rd_reg) < $signed(tok_reg.key));
    assign cand   = tok_reg.vld && !tok_reg.clr && tok_reg.last && valid_reg
                    && !smark_reg && ge_eff;

    always_comb
    begin
        tok_out      = tok_reg;
        tok_out.mark = tok_reg.mark | cand;
    end

    // stored features and mark
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg <= mem[tok_in.pos[AW-1:0]];
            if (tok_reg.vld && !tok_reg.clr && is_new)
            begin
                mem[tok_reg.pos[AW-1:0]] <= tok_reg.key;
                if (tok_reg.last)
                begin
                    smark_reg <= tok_reg.mark;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.vld <= 1'b0;
            valid_reg   <= 1'b0;
            ge_reg      <= 1'b1;
        end
        else if (adv)
        begin
            tok_reg <= tok_in;
            if (tok_reg.vld)
            begin
                if (tok_reg.clr)
                begin
                    valid_reg <= 1'b0;
                    ge_reg    <= 1'b1;
                end
                else if (is_new && tok_reg.last)
                begin
                    valid_reg <= 1'b1;
                    ge_reg    <= 1'b1;
                end
                else if (valid_reg)
                begin
                    ge_reg <= tok_reg.last ? 1'b1 : ge_eff;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/pdf_checker.sv =====
// ----------------------------------------------------------------------------
// pdf_checker
// Port-level checks of the pareto dominance filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pdf_checker #(
    parameter int MAX_OBJECTS = 64
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [pdf_pkg::IDX_W-1:0] object_index,
    input wire logic                      marked,
    input wire logic                      overflow
);
    import pdf_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(object_index)
            && $stable(marked) && $stable(overflow))
        else $error("result changed while stalled");

    // stall reaches the input side and nothing else stops it
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == !(out_valid && !out_ready))
        else $error("in_ready does not follow output stall");

    // with MAX_OBJECTS of 64 or more, dropped objects report the saturated index
    a_ovf_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> (MAX_OBJECTS < 64) || (object_index == IDX_SAT))
        else $error("overflow with unsaturated index");

    // no result right after reset
    a_rst: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind pareto_dominance_filter pdf_checker #(
    .MAX_OBJECTS (MAX_OBJECTS)
) u_pdf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .object_index (object_index),
    .marked       (marked),
    .overflow     (overflow)
);

`default_nettype wire
